// ===== design/proximity_gated_audio_forwarder_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the proximity gated audio forwarder.
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_GATED_AUDIO_FORWARDER_MACROS_SVH
`define PROXIMITY_GATED_AUDIO_FORWARDER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PGAF_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

`define PGAF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define PGAF_ASSERT_SAME(label, ante, cons)

`define PGAF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== design/pgaf_pkg.sv =====
// ----------------------------------------------------------------------------
// pgaf_pkg
// Types and constants of the proximity gated audio forwarder.
// ----------------------------------------------------------------------------
package pgaf_pkg;

   localparam logic [1:0] ACTION_MODE  = 2'd0;
   localparam logic [1:0] ACTION_AUDIO = 2'd1;
   localparam logic [1:0] ACTION_ECHO  = 2'd2;

   localparam logic [1:0] MODE_STOP     = 2'd0;
   localparam logic [1:0] MODE_MANUAL   = 2'd1;
   localparam logic [1:0] MODE_DISTANCE = 2'd2;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_STOP   = 2'd1;
   localparam logic [1:0] KIND_READY  = 2'd2;

   localparam logic [1:0] CSR_START_DISTANCE = 2'd0;
   localparam logic [1:0] CSR_STOP_DISTANCE  = 2'd1;
   localparam logic [1:0] CSR_MISS_LIMIT     = 2'd2;

   localparam logic [7:0] SAMPLE_CEILING  = 8'd254;
   localparam logic [7:0] STOP_MARKER     = 8'hFF;
   localparam logic [7:0] READY_MARKER    = 8'h52;
   localparam logic [7:0] SAMPLE_MIDPOINT = 8'd128;
   localparam logic [7:0] MISS_SATURATE   = 8'hFF;

   localparam logic [7:0] START_DISTANCE_RESET = 8'd10;
   localparam logic [7:0] STOP_DISTANCE_RESET  = 8'd15;
   localparam logic [7:0] MISS_LIMIT_RESET     = 8'd5;

   localparam int CM_DIVISOR = 58;
   localparam int CM_SHIFT   = 22;
   localparam int DIST_WIDTH = 11;
   localparam int PROD_WIDTH = 33;
   localparam logic [16:0] CM_RECIP = 17'((2 ** CM_SHIFT + CM_DIVISOR - 1) / CM_DIVISOR);

   typedef struct packed {
      logic [1:0]  action;
      logic [1:0]  mode_request;
      logic [7:0]  sample;
      logic [15:0] echo_us;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] out_kind;
   } rsp_type;

endpackage

// ===== design/proximity_gated_audio_forwarder.sv =====
// ----------------------------------------------------------------------------
// proximity_gated_audio_forwarder
// Mode, audio and echo request handling with distance gated recording.
// ----------------------------------------------------------------------------
// One request is accepted every cycle while results are taken. An accepted
// request sits in the input register. There it is evaluated in a single pass
// against the mode and recording state. Its result is offered from the
// output register. The evaluation path is one 16 by 17 bit multiply
// (echo to centimetres) followed by an 11 bit compare. A result that is not
// taken holds the input register, and the input stalls until rsp_ready
// returns. This holds even for requests that yield no result. Requests that
// yield no result leave the pipe without a response. Registers are written at
// any time through the csr port and take effect on the next evaluated request.
`include "proximity_gated_audio_forwarder_macros.svh"

module proximity_gated_audio_forwarder
   import pgaf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   logic       s1_valid_ff;
   req_type    s1_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic [1:0] mode_ff, mode_in;
   logic       recording_ff, recording_in;
   logic [7:0] prev_ff, prev_in;
   logic [7:0] miss_ff, miss_in;

   logic [7:0] start_cm_ff, stop_cm_ff, miss_limit_ff;

   logic                  s1_advance;
   logic                  emit;
   logic [PROD_WIDTH-1:0] prod;
   logic [DIST_WIDTH-1:0] dist_cm;
   logic [8:0]            sum;
   logic [7:0]            mean;
   logic [7:0]            miss_next;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign prod    = {17'd0, s1_data_ff.echo_us} * {16'd0, CM_RECIP};
   assign dist_cm = prod[CM_SHIFT +: DIST_WIDTH];
   assign sum  = {1'b0, prev_ff} + {1'b0, s1_data_ff.sample};
   assign mean = (sum[8:1] > SAMPLE_CEILING) ? SAMPLE_CEILING : sum[8:1];
   assign miss_next = (miss_ff < MISS_SATURATE) ? miss_ff + 8'd1 : miss_ff;

   always_comb begin
      mode_in      = mode_ff;
      recording_in = recording_ff;
      prev_in      = prev_ff;
      miss_in      = miss_ff;
      emit         = 1'b0;
      rsp_data_in  = rsp_data_ff;
      case (s1_data_ff.action)
         ACTION_MODE: begin
            if (s1_data_ff.mode_request inside {MODE_STOP, MODE_MANUAL, MODE_DISTANCE}) begin
               mode_in      = s1_data_ff.mode_request;
               recording_in = 1'b0;
               miss_in      = 8'd0;
               prev_in      = SAMPLE_MIDPOINT;
               if (s1_data_ff.mode_request == MODE_MANUAL) begin
                  emit                 = 1'b1;
                  rsp_data_in.out_byte = READY_MARKER;
                  rsp_data_in.out_kind = KIND_READY;
               end
            end
         end
         ACTION_AUDIO: begin
            if (mode_ff == MODE_MANUAL || (mode_ff == MODE_DISTANCE && recording_ff)) begin
               prev_in              = s1_data_ff.sample;
               emit                 = 1'b1;
               rsp_data_in.out_byte = mean;
               rsp_data_in.out_kind = KIND_SAMPLE;
            end
         end
         ACTION_ECHO: begin
            if (mode_ff == MODE_DISTANCE) begin
               if (!recording_ff && dist_cm <= {3'd0, start_cm_ff}) begin
                  recording_in = 1'b1;
                  miss_in      = 8'd0;
                  prev_in      = SAMPLE_MIDPOINT;
               end else if (recording_ff && dist_cm > {3'd0, stop_cm_ff}) begin
                  if (miss_next >= miss_limit_ff) begin
                     recording_in         = 1'b0;
                     miss_in              = 8'd0;
                     emit                 = 1'b1;
                     rsp_data_in.out_byte = STOP_MARKER;
                     rsp_data_in.out_kind = KIND_STOP;
                  end else begin
                     miss_in = miss_next;
                  end
               end else begin
                  miss_in = 8'd0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_advance && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= MODE_STOP;
         recording_ff  <= 1'b0;
         prev_ff       <= SAMPLE_MIDPOINT;
         miss_ff       <= 8'd0;
         start_cm_ff   <= START_DISTANCE_RESET;
         stop_cm_ff    <= STOP_DISTANCE_RESET;
         miss_limit_ff <= MISS_LIMIT_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s1_advance) begin
            mode_ff      <= mode_in;
            recording_ff <= recording_in;
            prev_ff      <= prev_in;
            miss_ff      <= miss_in;
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_START_DISTANCE: start_cm_ff   <= csr_data;
               CSR_STOP_DISTANCE:  stop_cm_ff    <= csr_data;
               CSR_MISS_LIMIT:     miss_limit_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (s1_advance && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   `PGAF_ASSERT_SAME(a_rec_needs_distance, recording_ff, mode_ff == MODE_DISTANCE)
   `PGAF_ASSERT_SAME(a_stop_byte, rsp_valid_ff && rsp_data_ff.out_kind == KIND_STOP,
      rsp_data_ff.out_byte == STOP_MARKER)
   `PGAF_ASSERT_SAME(a_sample_not_marker, rsp_valid_ff && rsp_data_ff.out_kind == KIND_SAMPLE,
      rsp_data_ff.out_byte != STOP_MARKER)
   `PGAF_ASSERT_NEXT(a_stop_ends_rec, s1_advance && emit && rsp_data_in.out_kind == KIND_STOP,
      !recording_ff && miss_ff == 8'd0)

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the proximity gated audio forwarder. A table of
// directed requests covers the mode commands, the sample clamp, echo
// thresholds and ignored requests. Random phases follow, each under its own
// register setting, with idle bursts on both channels. Every accepted request
// runs through a predictor, and results are compared field by field in order.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pgaf_pkg::*;

   localparam logic [1:0] ACTION_UNUSED = 2'd3;
   localparam logic [1:0] MODE_UNUSED   = 2'd3;
   localparam int ITEMS_PER_PHASE = 60;
   localparam int PHASE_COUNT     = 6;

   typedef struct {
      req_type item;
      bit      typed;
      bit      typed_has;
      rsp_type typed_rsp;
   } stim_row_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = CSR_START_DISTANCE;
   logic [7:0] csr_data = '0;

   logic [1:0] mode_now;
   bit         recording_now;
   logic [7:0] prev_sample_now;
   logic [7:0] misses_now;
   logic [7:0] start_cfg;
   logic [7:0] stop_cfg;
   logic [7:0] limit_cfg;

   rsp_type      pending_outputs[$];
   stim_row_type directed_rows[$];

   bit      row_typed = 1'b0;
   bit      row_has = 1'b0;
   rsp_type row_rsp = '0;
   bit      quiet = 1'b0;
   int      sender_calm = 0;
   int      mismatches = 0;
   int      requests_taken = 0;
   int      results_checked = 0;
   int      stop_markers = 0;
   int      reg_writes = 0;

   proximity_gated_audio_forwarder uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic void forward_request(input req_type r, output bit has,
                                           output rsp_type o);
      int dist_cm;
      int mean;
      has = 1'b0;
      o = '0;
      case (r.action)
         ACTION_MODE: begin
            if (r.mode_request != MODE_UNUSED) begin
               mode_now = r.mode_request;
               recording_now = 1'b0;
               misses_now = '0;
               prev_sample_now = SAMPLE_MIDPOINT;
               if (r.mode_request == MODE_MANUAL) begin
                  has = 1'b1;
                  o.out_byte = READY_MARKER;
                  o.out_kind = KIND_READY;
               end
            end
         end
         ACTION_AUDIO: begin
            if (mode_now == MODE_MANUAL || (mode_now == MODE_DISTANCE && recording_now)) begin
               mean = (int'(prev_sample_now) + int'(r.sample)) >> 1;
               if (mean > int'(SAMPLE_CEILING))
                  mean = int'(SAMPLE_CEILING);
               prev_sample_now = r.sample;
               has = 1'b1;
               o.out_byte = 8'(mean);
               o.out_kind = KIND_SAMPLE;
            end
         end
         ACTION_ECHO: begin
            if (mode_now == MODE_DISTANCE) begin
               dist_cm = int'(r.echo_us) / CM_DIVISOR;
               if (!recording_now && dist_cm <= int'(start_cfg)) begin
                  recording_now = 1'b1;
                  misses_now = '0;
                  prev_sample_now = SAMPLE_MIDPOINT;
               end else if (recording_now && dist_cm > int'(stop_cfg)) begin
                  if (misses_now < MISS_SATURATE)
                     misses_now = misses_now + 8'd1;
                  if (misses_now >= limit_cfg) begin
                     recording_now = 1'b0;
                     misses_now = '0;
                     has = 1'b1;
                     o.out_byte = STOP_MARKER;
                     o.out_kind = KIND_STOP;
                  end
               end else begin
                  misses_now = '0;
               end
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      bit      has;
      rsp_type predicted;
      rsp_type oldest;
      if (reset) begin
         mode_now = MODE_STOP;
         recording_now = 1'b0;
         prev_sample_now = SAMPLE_MIDPOINT;
         misses_now = '0;
         start_cfg = START_DISTANCE_RESET;
         stop_cfg = STOP_DISTANCE_RESET;
         limit_cfg = MISS_LIMIT_RESET;
         pending_outputs.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            reg_writes++;
            case (csr_index)
               CSR_START_DISTANCE: start_cfg = csr_data;
               CSR_STOP_DISTANCE:  stop_cfg = csr_data;
               CSR_MISS_LIMIT:     limit_cfg = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_outputs.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, got byte %0d kind %0d",
                        $time, rsp_data.out_byte, rsp_data.out_kind);
            end else begin
               oldest = pending_outputs.pop_front();
               results_checked++;
               if (rsp_data.out_kind == KIND_STOP)
                  stop_markers++;
               if (rsp_data.out_byte !== oldest.out_byte) begin
                  mismatches++;
                  $display("%0t: out_byte expected %0d, got %0d",
                           $time, oldest.out_byte, rsp_data.out_byte);
               end
               if (rsp_data.out_kind !== oldest.out_kind) begin
                  mismatches++;
                  $display("%0t: out_kind expected %0d, got %0d",
                           $time, oldest.out_kind, rsp_data.out_kind);
               end
            end
         end
         if (req_valid && req_ready) begin
            requests_taken++;
            forward_request(req_data, has, predicted);
            if (row_typed) begin
               has = row_has;
               predicted = row_rsp;
            end
            if (has)
               pending_outputs.push_back(predicted);
         end
      end
   end

   always @(negedge clock) begin
      int stall_left;
      int calm_left;
      if (quiet || reset) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (calm_left > 0) begin
         calm_left--;
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 15) - 1;
         if ($urandom_range(0, 3) == 0)
            calm_left = $urandom_range(20, 80);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic void add_row(input logic [1:0] act, input logic [1:0] mode,
                                   input logic [7:0] smp, input logic [15:0] echo,
                                   input bit typed = 1'b0, input bit has = 1'b0,
                                   input logic [7:0] out_byte = '0,
                                   input logic [1:0] out_kind = KIND_SAMPLE);
      stim_row_type r;
      r.item.action = act;
      r.item.mode_request = mode;
      r.item.sample = smp;
      r.item.echo_us = echo;
      r.typed = typed;
      r.typed_has = has;
      r.typed_rsp.out_byte = out_byte;
      r.typed_rsp.out_kind = out_kind;
      directed_rows.push_back(r);
   endfunction

   function automatic req_type random_request();
      req_type r;
      int pick;
      int target_cm;
      r = req_type'({$urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         r.action = ACTION_MODE;
         pick = $urandom_range(0, 19);
         r.mode_request = (pick < 10) ? MODE_DISTANCE : (pick < 15) ? MODE_MANUAL :
                          (pick < 18) ? MODE_STOP : MODE_UNUSED;
      end else if (pick < 51) begin
         r.action = ACTION_AUDIO;
      end else if (pick < 96) begin
         r.action = ACTION_ECHO;
         pick = $urandom_range(0, 9);
         if (pick < 4)
            target_cm = int'(start_cfg) + $urandom_range(0, 4) - 2;
         else if (pick < 8)
            target_cm = int'(stop_cfg) + $urandom_range(0, 4) - 1;
         else
            target_cm = -1;
         if (target_cm >= 0)
            r.echo_us = 16'(target_cm * CM_DIVISOR + $urandom_range(0, CM_DIVISOR - 1));
      end else begin
         r.action = ACTION_UNUSED;
      end
      return r;
   endfunction

   task automatic send_request(input req_type item);
      if (!quiet && sender_calm == 0 && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
         if ($urandom_range(0, 3) == 0)
            sender_calm = $urandom_range(10, 40);
      end else if (sender_calm > 0) begin
         sender_calm--;
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] start_cm, input logic [7:0] stop_cm,
                                 input logic [7:0] limit);
      logic [1:0] idx[3];
      logic [7:0] val[3];
      idx = '{CSR_START_DISTANCE, CSR_STOP_DISTANCE, CSR_MISS_LIMIT};
      val = '{start_cm, stop_cm, limit};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      req_type    item;
      int         useful;
      logic [7:0] start_cm;
      logic [7:0] stop_cm;
      logic [7:0] limit;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_row(ACTION_AUDIO, MODE_MANUAL, 8'd200, 16'h1234, 1'b1, 1'b0);
      add_row(ACTION_ECHO, MODE_DISTANCE, 8'h5A, 16'd0, 1'b1, 1'b0);
      add_row(ACTION_MODE, MODE_MANUAL, 8'hA5, 16'hFFFF, 1'b1, 1'b1, READY_MARKER,
              KIND_READY);
      add_row(ACTION_AUDIO, MODE_UNUSED, 8'd255, 16'h0000, 1'b1, 1'b1, 8'd191, KIND_SAMPLE);
      add_row(ACTION_AUDIO, MODE_STOP, 8'd255, 16'hFFFF, 1'b1, 1'b1, SAMPLE_CEILING,
              KIND_SAMPLE);
      add_row(ACTION_AUDIO, MODE_DISTANCE, 8'd0, 16'h8000);
      add_row(ACTION_AUDIO, MODE_MANUAL, 8'd0, 16'h7FFF, 1'b1, 1'b1, 8'd0, KIND_SAMPLE);
      add_row(ACTION_MODE, MODE_UNUSED, 8'hFF, 16'hFFFF, 1'b1, 1'b0);
      add_row(ACTION_UNUSED, MODE_DISTANCE, 8'hFF, 16'hFFFF, 1'b1, 1'b0);
      add_row(ACTION_AUDIO, MODE_STOP, 8'd1, 16'd0);
      add_row(ACTION_MODE, MODE_DISTANCE, 8'h00, 16'h0000, 1'b1, 1'b0);
      add_row(ACTION_AUDIO, MODE_STOP, 8'd77, 16'd0, 1'b1, 1'b0);
      add_row(ACTION_ECHO, MODE_STOP, 8'd0, 16'hFFFF);
      add_row(ACTION_ECHO, MODE_STOP, 8'd0, 16'd637);
      add_row(ACTION_AUDIO, MODE_STOP, 8'd100, 16'd0);
      add_row(ACTION_ECHO, MODE_STOP, 8'd0, 16'd928);
      add_row(ACTION_ECHO, MODE_STOP, 8'd0, 16'd927);
      repeat (4) add_row(ACTION_ECHO, MODE_STOP, 8'd0, 16'hFFFF);
      add_row(ACTION_ECHO, MODE_STOP, 8'd0, 16'hFFFF, 1'b1, 1'b1, STOP_MARKER, KIND_STOP);
      add_row(ACTION_AUDIO, MODE_STOP, 8'd50, 16'd0);
      add_row(ACTION_ECHO, MODE_STOP, 8'd0, 16'd0);
      add_row(ACTION_MODE, MODE_STOP, 8'd0, 16'd0, 1'b1, 1'b0);

      foreach (directed_rows[i]) begin
         row_typed = directed_rows[i].typed;
         row_has = directed_rows[i].typed_has;
         row_rsp = directed_rows[i].typed_rsp;
         send_request(directed_rows[i].item);
      end
      row_typed = 1'b0;

      for (int p = 0; p < PHASE_COUNT; p++) begin
         if (p > 0) begin
            wait_idle();
            case (p)
               1: begin start_cm = 8'd0;   stop_cm = 8'd0;   limit = 8'd1;   end
               2: begin start_cm = 8'd255; stop_cm = 8'd255; limit = 8'd255; end
               3: begin start_cm = 8'd0;   stop_cm = 8'd255; limit = 8'd0;   end
               4: begin
                  start_cm = 8'($urandom_range(0, 60));
                  stop_cm = 8'(int'(start_cm) + $urandom_range(0, 30));
                  limit = 8'($urandom_range(1, 8));
               end
               default: begin start_cm = 8'd30; stop_cm = 8'd40; limit = 8'd3; end
            endcase
            apply_settings(start_cm, stop_cm, limit);
         end
         quiet = (p == PHASE_COUNT - 1);
         item = random_request();
         item.action = ACTION_MODE;
         item.mode_request = MODE_DISTANCE;
         send_request(item);
         useful = 0;
         while (useful < ITEMS_PER_PHASE) begin
            item = random_request();
            if (item.action != ACTION_UNUSED &&
                !(item.action == ACTION_MODE && item.mode_request == MODE_UNUSED))
               useful++;
            send_request(item);
         end
      end

      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      $display("Run covered %0d requests, %0d checked results (%0d stop markers)",
               requests_taken, results_checked, stop_markers);
      $display("Register writes: %0d over %0d register settings", reg_writes, PHASE_COUNT);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d results still expected", pending_outputs.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/pgaf_pkg.sv
design/proximity_gated_audio_forwarder.sv
verif/tb.sv
